### hdl/keypad_decode_debounce_unit_assert.svh
// Assertion macros used by the keypad decoder checker.
// Needs clk and rst_n in the scope of each use.
`ifndef KEYPAD_DECODE_DEBOUNCE_UNIT_ASSERT_SVH
`define KEYPAD_DECODE_DEBOUNCE_UNIT_ASSERT_SVH

// same-cycle implication
`define KDD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/kdd_pkg.sv
// Shared types and constants for the keypad decode and debounce unit.
// No dependencies.
package kdd_pkg;

    localparam int KEY_COUNT   = 16;
    localparam int SCAN_WIDTH  = 16;
    localparam int SCANNED     = (KEY_COUNT < SCAN_WIDTH) ? KEY_COUNT : SCAN_WIDTH;
    localparam int CLASS_WIDTH = 5;
    localparam int KEY_WIDTH   = 4;
    localparam int COUNT_WIDTH = 8;
    localparam int ADDR_WIDTH  = 3;
    localparam int DATA_WIDTH  = 32;

    localparam logic [CLASS_WIDTH-1:0] CLASS_NONE = 5'd16;
    localparam logic [CLASS_WIDTH-1:0] CLASS_MANY = 5'd17;

    localparam logic [COUNT_WIDTH-1:0] DEBOUNCE_RESET = 8'd5;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX      = 8'hFF;

    // register index, taken from paddr[2]
    localparam logic REG_DEBOUNCE_COUNT = 1'b0;

    typedef struct packed {
        logic                 emit;
        logic [KEY_WIDTH-1:0] key;
    } result_t;

endpackage

### hdl/keypad_decode_debounce_unit.sv
// Top level of the keypad decode and debounce unit: scan input register,
// classifier, debounce state, result register and configuration port.
// Depends on kdd_pkg, kdd_classify and kdd_debounce.
//
// Usage:
//   Scan channel (scan_valid/scan_stall/scan_bits) carries one full 16-bit
//   keypad scan per transaction. Key channel (key_valid/key_stall/
//   key_position) carries one debounced key per transaction, issued on the
//   first no-key scan after a key has been captured.
//   A scan in the input register is classified there and applied to the
//   debounce state as it leaves; its result enters the result register.
//   Throughput is one scan per cycle while no result is stalled: the
//   input register and result register form a two-stage pipeline with
//   one state update per cycle. When key_stall holds a pending result,
//   the scan in the input register waits and scan_stall rises; with an
//   empty input register one more scan is still taken.
//   Reset clears the pipeline, re-arms the debounce logic and sets
//   debounce_count to 5. The APB port writes debounce_count at address 0;
//   write it only while idle.
module keypad_decode_debounce_unit
#(
    parameter int KEY_COUNT = kdd_pkg::KEY_COUNT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              scan_valid,
    output logic                              scan_stall,
    input  logic [kdd_pkg::SCAN_WIDTH-1:0]    scan_bits,
    output logic                              key_valid,
    input  logic                              key_stall,
    output logic [kdd_pkg::KEY_WIDTH-1:0]     key_position,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kdd_pkg::ADDR_WIDTH-1:0]    paddr,
    input  logic [kdd_pkg::DATA_WIDTH-1:0]    pwdata,
    output logic [kdd_pkg::DATA_WIDTH-1:0]    prdata,
    output logic                              pready
);

    logic [kdd_pkg::COUNT_WIDTH-1:0] debounce_count_reg, debounce_count_next;
    logic                            scan_valid_reg, scan_valid_next;
    logic [kdd_pkg::SCAN_WIDTH-1:0]  scan_reg, scan_next;
    logic                            key_valid_reg, key_valid_next;
    logic [kdd_pkg::KEY_WIDTH-1:0]   key_reg, key_next;
    logic                            out_free;
    logic                            step;
    logic                            scan_accept;
    logic [kdd_pkg::CLASS_WIDTH-1:0] cls;
    kdd_pkg::result_t                result;

    // configuration port
    assign pready = 1'b1;

    always_comb
    begin
        debounce_count_next = debounce_count_reg;
        if (psel && penable && pwrite && (paddr[2] == kdd_pkg::REG_DEBOUNCE_COUNT))
        begin
            debounce_count_next = pwdata[kdd_pkg::COUNT_WIDTH-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == kdd_pkg::REG_DEBOUNCE_COUNT)
        begin
            prdata = {{(kdd_pkg::DATA_WIDTH-kdd_pkg::COUNT_WIDTH){1'b0}},
                      debounce_count_reg};
        end
    end

    // pipeline control
    assign out_free    = !key_valid_reg || !key_stall;
    assign step        = scan_valid_reg && out_free;
    assign scan_stall  = scan_valid_reg && !out_free;
    assign scan_accept = scan_valid && !scan_stall;

    always_comb
    begin
        scan_valid_next = scan_valid_reg;
        scan_next       = scan_reg;
        if (scan_accept)
        begin
            scan_valid_next = 1'b1;
            scan_next       = scan_bits;
        end
        else if (step)
        begin
            scan_valid_next = 1'b0;
        end
    end

    kdd_classify
    #(
        .KEY_COUNT (KEY_COUNT)
    )
    u_classify
    (
        .scan (scan_reg),
        .cls  (cls)
    );

    kdd_debounce u_debounce
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .cls            (cls),
        .debounce_count (debounce_count_reg),
        .result         (result)
    );

    always_comb
    begin
        key_valid_next = key_valid_reg;
        key_next       = key_reg;
        if (out_free)
        begin
            key_valid_next = result.emit;
            if (result.emit)
            begin
                key_next = result.key;
            end
        end
    end

    assign key_valid    = key_valid_reg;
    assign key_position = key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_count_reg <= kdd_pkg::DEBOUNCE_RESET;
            scan_valid_reg     <= 1'b0;
            key_valid_reg      <= 1'b0;
        end
        else
        begin
            debounce_count_reg <= debounce_count_next;
            scan_valid_reg     <= scan_valid_next;
            key_valid_reg      <= key_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        key_reg  <= key_next;
    end

endmodule

### hdl/kdd_classify.sv
// Scan classifier: no key, many keys, or position of the single pressed key.
// Depends on kdd_pkg.
module kdd_classify
#(
    parameter int KEY_COUNT = kdd_pkg::KEY_COUNT
)
(
    input  logic [kdd_pkg::SCAN_WIDTH-1:0]  scan,
    output logic [kdd_pkg::CLASS_WIDTH-1:0] cls
);

    localparam int SCANNED = (KEY_COUNT < kdd_pkg::SCAN_WIDTH) ? KEY_COUNT
                                                              : kdd_pkg::SCAN_WIDTH;

    logic [kdd_pkg::SCAN_WIDTH-1:0] masked;
    logic [kdd_pkg::SCAN_WIDTH-1:0] low_cleared;
    logic [kdd_pkg::KEY_WIDTH-1:0]  pos;

    always_comb
    begin
        for (int i = 0; i < kdd_pkg::SCAN_WIDTH; i++)
        begin
            masked[i] = (i < SCANNED) ? scan[i] : 1'b0;
        end
    end

    assign low_cleared = masked & (masked - kdd_pkg::SCAN_WIDTH'(1));

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < kdd_pkg::SCAN_WIDTH; i++)
        begin
            if (masked[i])
            begin
                pos = kdd_pkg::KEY_WIDTH'(i);
            end
        end
    end

    always_comb
    begin
        priority if (masked == '0)
        begin
            cls = kdd_pkg::CLASS_NONE;
        end
        else if (low_cleared != '0)
        begin
            cls = kdd_pkg::CLASS_MANY;
        end
        else
        begin
            cls = {1'b0, pos};
        end
    end

endmodule

### hdl/kdd_debounce.sv
// Debounce and release tracking state; one scan class per step.
// Depends on kdd_pkg.
module kdd_debounce
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic [kdd_pkg::CLASS_WIDTH-1:0]  cls,
    input  logic [kdd_pkg::COUNT_WIDTH-1:0]  debounce_count,
    output kdd_pkg::result_t                 result
);

    logic [kdd_pkg::CLASS_WIDTH-1:0] previous_class_reg, previous_class_next;
    logic [kdd_pkg::COUNT_WIDTH-1:0] stable_count_reg, stable_count_next;
    logic                            waiting_release_reg, waiting_release_next;
    logic [kdd_pkg::KEY_WIDTH-1:0]   held_key_reg, held_key_next;
    logic [kdd_pkg::COUNT_WIDTH-1:0] count_upd;
    logic                            is_single;

    assign is_single = (cls[kdd_pkg::CLASS_WIDTH-1] == 1'b0);

    always_comb
    begin
        if (cls != previous_class_reg)
        begin
            count_upd = '0;
        end
        else if (stable_count_reg != kdd_pkg::COUNT_MAX)
        begin
            count_upd = stable_count_reg + kdd_pkg::COUNT_WIDTH'(1);
        end
        else
        begin
            count_upd = stable_count_reg;
        end
    end

    always_comb
    begin
        previous_class_next  = previous_class_reg;
        stable_count_next    = stable_count_reg;
        waiting_release_next = waiting_release_reg;
        held_key_next        = held_key_reg;
        result.emit          = 1'b0;
        result.key           = held_key_reg;
        if (step)
        begin
            if (waiting_release_reg)
            begin
                if (cls == kdd_pkg::CLASS_NONE)
                begin
                    result.emit          = 1'b1;
                    waiting_release_next = 1'b0;
                    previous_class_next  = kdd_pkg::CLASS_NONE;
                    stable_count_next    = '0;
                end
            end
            else
            begin
                previous_class_next = cls;
                stable_count_next   = count_upd;
                if (is_single && (count_upd >= debounce_count))
                begin
                    held_key_next        = cls[kdd_pkg::KEY_WIDTH-1:0];
                    waiting_release_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_class_reg  <= kdd_pkg::CLASS_NONE;
            stable_count_reg    <= '0;
            waiting_release_reg <= 1'b0;
            held_key_reg        <= '0;
        end
        else
        begin
            previous_class_reg  <= previous_class_next;
            stable_count_reg    <= stable_count_next;
            waiting_release_reg <= waiting_release_next;
            held_key_reg        <= held_key_next;
        end
    end

endmodule

### hdl/kdd_checker.sv
// Port-level checker for the keypad decode and debounce unit, with its bind.
// Depends on kdd_pkg and keypad_decode_debounce_unit_assert.svh.
`include "keypad_decode_debounce_unit_assert.svh"

module kdd_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              scan_stall,
    input logic                              key_valid,
    input logic                              key_stall,
    input logic [kdd_pkg::KEY_WIDTH-1:0]     key_position
);

    // stalled key transaction holds
    `KDD_ASSERT_NEXT(a_key_hold, key_valid && key_stall,
        key_valid && $stable(key_position), "key transaction changed while stalled")

    // scans are only held back by a blocked result
    `KDD_ASSERT_NOW(a_scan_stall_cause, scan_stall,
        key_valid && key_stall, "scan stalled without a blocked result")

    // a key needs a capture and a release scan, so results never run back to back
    `KDD_ASSERT_NEXT(a_no_back_to_back, key_valid && !key_stall,
        !key_valid, "two key transactions in consecutive cycles")

endmodule

bind keypad_decode_debounce_unit kdd_checker u_kdd_checker (.*);
